// ===== rtl/wsp_pkg.sv =====
// Package with the shared types and constants of the WAV stream parser.
package wsp_pkg;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              sample_valid;
		logic signed [31:0] sample_value;
		logic [15:0]       channel_index;
		logic [2:0]        stream_status;
	} out_item_t;

	// Work handed from the parser front to the conversion back end.
	typedef struct packed {
		logic        is_sample;
		logic [31:0] assembly;
		logic [15:0] audio_format;
		logic [12:0] sample_bytes;
		logic [15:0] channel;
		logic [2:0]  status;
	} job_t;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_TAG   = 3'd2;
	localparam logic [2:0] ST_FMT   = 3'd3;
	localparam logic [2:0] ST_TRUNC = 3'd4;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	typedef enum logic [13:0] {
		PH_RIFF_TAG  = 14'b00000000000001,
		PH_RIFF_SIZE = 14'b00000000000010,
		PH_WAVE_TAG  = 14'b00000000000100,
		PH_FMT_ID    = 14'b00000000001000,
		PH_SKIPSZ_A  = 14'b00000000010000,
		PH_SKIP_A    = 14'b00000000100000,
		PH_FMT_SIZE  = 14'b00000001000000,
		PH_FMT_BODY  = 14'b00000010000000,
		PH_DATA_ID   = 14'b00000100000000,
		PH_SKIPSZ_B  = 14'b00001000000000,
		PH_SKIP_B    = 14'b00010000000000,
		PH_DATA_SIZE = 14'b00100000000000,
		PH_DATA      = 14'b01000000000000,
		PH_HALT      = 14'b10000000000000
	} phase_t;

endpackage

// ===== rtl/wav_stream_parser_top.sv =====
// Top level of the WAV stream parser.
//  channel  | direction | handshake             | payload
//  in       | input     | push / full           | in_item  (stream_byte, last_byte)
//  out      | output    | empty / pop           | out_item (valid, value, channel, status)
// One byte is taken per cycle while full is low; the front parser updates its
// state in that same cycle. A result is registered in a job queue of QUEUE_DEPTH
// entries and reaches the output register through a combinational conversion.
// Reset clears the parser and empties the queue and the output register.
// Full rises only when the queue fills while results are not popped.
module wav_stream_parser_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  wsp_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output wsp_pkg::out_item_t out_item
);
	import wsp_pkg::*;

	logic take, job_valid, q_empty, q_pop;
	job_t job_in, job_out;

	assign take = push && !full;

	wsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (in_item),
		.job_valid (job_valid),
		.job       (job_in)
	);

	wsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wdata  (job_in),
		.full   (full),
		.rd     (q_pop),
		.empty  (q_empty),
		.rdata  (job_out)
	);

	wsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job       (job_out),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (out_item)
	);
endmodule

// ===== rtl/wsp_front.sv =====
// Byte parser front end that walks the chunks and assembles samples.
module wsp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  wsp_pkg::in_item_t item,
	output logic             job_valid,
	output wsp_pkg::job_t    job
);
	import wsp_pkg::*;

	phase_t      phase_q;
	logic [31:0] tag_q;
	logic [4:0]  fcnt_q;
	logic [31:0] skip_q;
	logic [15:0] afmt_q;
	logic [15:0] chtot_q;
	logic [12:0] sbytes_q;
	logic [31:0] drem_q;
	logic [31:0] asm_q;
	logic [12:0] sidx_q;
	logic [15:0] chcnt_q;

	phase_t      phase_d;
	logic [31:0] tag_d, skip_d, drem_d, asm_d, shifted;
	logic [4:0]  fcnt_d;
	logic [15:0] afmt_d, chtot_d, chcnt_d, chinc;
	logic [12:0] sbytes_d, sidx_d, sidx_inc;
	logic        field_done, got;
	logic [2:0]  status;

	assign shifted    = {item.stream_byte, tag_q[31:8]};
	assign field_done = (fcnt_q == 5'd3);
	assign sidx_inc   = sidx_q + 13'd1;
	assign chinc      = chcnt_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		tag_d    = tag_q;
		fcnt_d   = fcnt_q;
		skip_d   = skip_q;
		afmt_d   = afmt_q;
		chtot_d  = chtot_q;
		sbytes_d = sbytes_q;
		drem_d   = drem_q;
		asm_d    = asm_q;
		sidx_d   = sidx_q;
		chcnt_d  = chcnt_q;
		got      = 1'b0;
		status   = ST_RUN;
		unique case (phase_q)
			PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_ID, PH_DATA_ID,
			PH_SKIPSZ_A, PH_SKIPSZ_B, PH_FMT_SIZE, PH_DATA_SIZE: begin
				tag_d  = shifted;
				fcnt_d = field_done ? 5'd0 : fcnt_q + 5'd1;
				if (field_done) begin
					unique case (phase_q)
						PH_RIFF_TAG: begin
							if (shifted == TAG_RIFF) phase_d = PH_RIFF_SIZE;
							else begin
								status  = ST_TAG;
								phase_d = PH_HALT;
							end
						end
						PH_RIFF_SIZE: phase_d = PH_WAVE_TAG;
						PH_WAVE_TAG: begin
							if (shifted == TAG_WAVE) phase_d = PH_FMT_ID;
							else begin
								status  = ST_TAG;
								phase_d = PH_HALT;
							end
						end
						PH_FMT_ID: phase_d = (shifted == TAG_FMT) ? PH_FMT_SIZE : PH_SKIPSZ_A;
						PH_DATA_ID:
							phase_d = (shifted == TAG_DATA) ? PH_DATA_SIZE : PH_SKIPSZ_B;
						PH_SKIPSZ_A: begin
							skip_d  = shifted;
							phase_d = (shifted == 32'd0) ? PH_FMT_ID : PH_SKIP_A;
						end
						PH_SKIPSZ_B: begin
							skip_d  = shifted;
							phase_d = (shifted == 32'd0) ? PH_DATA_ID : PH_SKIP_B;
						end
						PH_FMT_SIZE: begin
							skip_d  = shifted;
							phase_d = (shifted == 32'd0) ? PH_DATA_ID : PH_FMT_BODY;
						end
						default: begin
							drem_d = shifted;
							if (chtot_q == 16'd0 || sbytes_q == 13'd0 || shifted == 32'd0)
							begin
								status  = ST_FMT;
								phase_d = PH_HALT;
							end else begin
								asm_d   = 32'd0;
								sidx_d  = 13'd0;
								chcnt_d = 16'd0;
								phase_d = PH_DATA;
							end
						end
					endcase
				end
			end
			PH_SKIP_A, PH_SKIP_B: begin
				skip_d = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
				if (skip_d == 32'd0) phase_d = (phase_q == PH_SKIP_A) ? PH_FMT_ID : PH_DATA_ID;
			end
			PH_FMT_BODY: begin
				tag_d = shifted;
				if (fcnt_q == 5'd1) afmt_d = shifted[31:16];
				else if (fcnt_q == 5'd3) chtot_d = shifted[31:16];
				else if (fcnt_q == 5'd15) sbytes_d = shifted[31:19];
				if (fcnt_q < 5'd16) fcnt_d = fcnt_q + 5'd1;
				skip_d = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
				if (skip_d == 32'd0) begin
					fcnt_d  = 5'd0;
					phase_d = PH_DATA_ID;
				end
			end
			PH_DATA: begin
				if (sidx_q < 13'd4) begin
					unique case (sidx_q[1:0])
						2'd0: asm_d[7:0]   = item.stream_byte;
						2'd1: asm_d[15:8]  = item.stream_byte;
						2'd2: asm_d[23:16] = item.stream_byte;
						default: asm_d[31:24] = item.stream_byte;
					endcase
				end
				drem_d = (drem_q != 32'd0) ? drem_q - 32'd1 : drem_q;
				sidx_d = sidx_inc;
				if (sidx_inc >= sbytes_q) begin
					got     = 1'b1;
					sidx_d  = 13'd0;
					chcnt_d = (chinc >= chtot_q) ? 16'd0 : chinc;
				end
				if (drem_d == 32'd0 && sidx_d == 13'd0 && chcnt_d == 16'd0) begin
					status  = ST_DONE;
					phase_d = PH_HALT;
				end
			end
			default: ;
		endcase
		if (item.last_byte && phase_q != PH_HALT && status == ST_RUN) status = ST_TRUNC;
	end

	assign job_valid        = take && (got || status != ST_RUN);
	assign job.is_sample    = got;
	assign job.assembly     = asm_d;
	assign job.audio_format = afmt_q;
	assign job.sample_bytes = sbytes_q;
	assign job.channel      = chcnt_q;
	assign job.status       = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF_TAG;
			tag_q    <= '0;
			fcnt_q   <= '0;
			skip_q   <= '0;
			afmt_q   <= '0;
			chtot_q  <= '0;
			sbytes_q <= '0;
			drem_q   <= '0;
			asm_q    <= '0;
			sidx_q   <= '0;
			chcnt_q  <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				phase_q  <= PH_RIFF_TAG;
				tag_q    <= '0;
				fcnt_q   <= '0;
				skip_q   <= '0;
				afmt_q   <= '0;
				chtot_q  <= '0;
				sbytes_q <= '0;
				drem_q   <= '0;
				asm_q    <= '0;
				sidx_q   <= '0;
				chcnt_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				tag_q    <= tag_d;
				fcnt_q   <= fcnt_d;
				skip_q   <= skip_d;
				afmt_q   <= afmt_d;
				chtot_q  <= chtot_d;
				sbytes_q <= sbytes_d;
				drem_q   <= drem_d;
				asm_q    <= got ? 32'd0 : asm_d;
				sidx_q   <= sidx_d;
				chcnt_q  <= chcnt_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_HALT && !item.last_byte) |-> !job_valid)
		else $error("Halted parser produced a transaction.");
	a_sample_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(take && got) |-> (phase_q == PH_DATA))
		else $error("Sample completed outside the data chunk.");
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.last_byte) |=> (phase_q == PH_RIFF_TAG && fcnt_q == 5'd0))
		else $error("Parser did not return to start after the last byte.");
`endif
endmodule

// ===== rtl/wsp_fifo.sv =====
// Short queue of jobs between the parser front and the conversion back end.
module wsp_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  wsp_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          empty,
	output wsp_pkg::job_t rdata
);
	import wsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd && !empty) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd) |=> full)
		else $error("Queue lost an entry while full.");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !full && !rd) |=> (cnt_q == $past(cnt_q) + (AW+1)'(1)))
		else $error("Queue count did not follow a write.");
	a_empty_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !wr) |=> empty)
		else $error("Queue became non-empty without a write.");
`endif
endmodule

// ===== rtl/wsp_back.sv =====
// Conversion back end that turns a queued job into a Q1.31 result.
module wsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_empty,
	input  wsp_pkg::job_t     job,
	output logic              job_pop,
	output logic              empty,
	input  logic              pop,
	output wsp_pkg::out_item_t result
);
	import wsp_pkg::*;

	out_item_t   res_q;
	logic        vld_q;
	logic [31:0] value, fmag, man;
	logic [7:0]  ex;
	logic        neg;
	logic [8:0]  sh;

	always_comb begin
		neg  = job.assembly[31];
		ex   = job.assembly[30:23];
		man  = {9'd0, job.assembly[22:0]};
		fmag = 32'd0;
		sh   = 9'd0;
		if (ex == 8'hFF) begin
			fmag = (man != 32'd0) ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end else begin
			if (ex == 8'd0) sh = 9'd1;
			else begin
				sh  = {1'b0, ex};
				man = man | 32'h0080_0000;
			end
			if (sh >= 9'd127) fmag = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else if (sh >= 9'd119) fmag = neg ? 32'd0 - (man << (sh - 9'd119))
				: (man << (sh - 9'd119));
			else if (sh > 9'd87) fmag = neg ? 32'd0 - (man >> (9'd119 - sh))
				: (man >> (9'd119 - sh));
			else fmag = 32'd0;
		end
		value = 32'd0;
		if (job.audio_format == FMT_PCM) begin
			unique case (job.sample_bytes)
				13'd1: value = {job.assembly[7:0] ^ 8'h80, 24'd0};
				13'd2: value = {job.assembly[15:0], 16'd0};
				13'd3: value = {job.assembly[23:0], 8'd0};
				13'd4: value = job.assembly;
				default: value = 32'd0;
			endcase
		end else if (job.audio_format == FMT_FLOAT && job.sample_bytes == 13'd4) begin
			value = fmag;
		end
		if (!job.is_sample) value = 32'd0;
	end

	assign job_pop = !job_empty && (!vld_q || pop);
	assign empty   = !vld_q;
	assign result  = res_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			res_q.sample_valid  <= job.is_sample;
			res_q.sample_value  <= value;
			res_q.channel_index <= job.is_sample ? job.channel : 16'd0;
			res_q.stream_status <= job.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (job_pop) vld_q <= 1'b1;
		else if (pop) vld_q <= 1'b0;
	end

`ifndef SYNTHESIS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !pop) |=> (vld_q && $stable(res_q)))
		else $error("Stalled result changed.");
	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> vld_q)
		else $error("Taken job left no result.");
	a_no_take_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !pop) |-> !job_pop)
		else $error("Job taken over a waiting result.");
`endif
endmodule

// ===== tb/sv/wav_stream_parser_top_tb.sv =====
// Self-checking testbench of the WAV stream parser with its own byte-level prediction.
module wav_stream_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   in_item;
	logic       empty;
	logic       pop;
	out_item_t  out_item;

	wav_stream_parser_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	in_item_t    byte_q[$];
	out_item_t   result_q[$];
	logic [7:0]  file_q[$];
	int          idle_pct;
	int          stall_pct;
	bit          hold_go;
	bit          hold_seen;
	int          hold_cnt;
	int          idle_cycles;
	int          fail_cnt;
	int          bytes_sent;
	int          samples_seen;
	int          status_seen;
	int          file_cnt;

	// Parser state mirrored from the block's behavior.
	phase_t      ph;
	logic [31:0] tag_sh;
	int unsigned fbc;
	logic [31:0] skip_rem;
	logic [15:0] afmt;
	logic [15:0] ch_total;
	logic [12:0] smp_bytes;
	logic [31:0] data_rem;
	logic [31:0] asm_word;
	int unsigned sb_idx;
	logic [15:0] ch_cnt;

	function automatic void parser_clear();
		ph = PH_RIFF_TAG;
		tag_sh = '0;
		fbc = 0;
		skip_rem = '0;
		afmt = '0;
		ch_total = '0;
		smp_bytes = '0;
		data_rem = '0;
		asm_word = '0;
		sb_idx = 0;
		ch_cnt = '0;
	endfunction

	function automatic bit shift_field(input logic [7:0] b);
		tag_sh = {b, tag_sh[31:8]};
		fbc++;
		if (fbc >= 4) begin
			fbc = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [31:0] float_q31(input logic [31:0] w);
		int          e;
		int          sh;
		logic [31:0] man;
		logic [31:0] mag;
		logic [31:0] sat;
		e = w[30:23];
		man = {9'b0, w[22:0]};
		sat = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (e == 255)
			return (man != 0) ? 32'h0 : sat;
		if (e == 0)
			e = 1;
		else
			man[23] = 1'b1;
		sh = e - 119;
		if (sh >= 8)
			return sat;
		if (sh >= 0)
			mag = man << sh;
		else if (sh > -32)
			mag = man >> (-sh);
		else
			mag = 0;
		return w[31] ? (32'h0 - mag) : mag;
	endfunction

	function automatic logic [31:0] sample_q31();
		if (afmt == FMT_PCM) begin
			case (smp_bytes)
				13'd1: return {asm_word[7:0] ^ 8'h80, 24'h0};
				13'd2: return {asm_word[15:0], 16'h0};
				13'd3: return {asm_word[23:0], 8'h0};
				13'd4: return asm_word;
				default: return 32'h0;
			endcase
		end
		if (afmt == FMT_FLOAT && smp_bytes == 13'd4)
			return float_q31(asm_word);
		return 32'h0;
	endfunction

	function automatic void parse_byte(input in_item_t it);
		logic [7:0]  b;
		bit          halted;
		bit          got;
		logic [31:0] value;
		logic [15:0] chan;
		logic [2:0]  status;
		out_item_t   r;
		b = it.stream_byte;
		halted = (ph == PH_HALT);
		got = 0;
		value = '0;
		chan = '0;
		status = ST_RUN;
		case (ph)
			PH_RIFF_TAG: if (shift_field(b)) begin
				if (tag_sh == TAG_RIFF) ph = PH_RIFF_SIZE;
				else begin status = ST_TAG; ph = PH_HALT; end
			end
			PH_RIFF_SIZE: if (shift_field(b)) ph = PH_WAVE_TAG;
			PH_WAVE_TAG: if (shift_field(b)) begin
				if (tag_sh == TAG_WAVE) ph = PH_FMT_ID;
				else begin status = ST_TAG; ph = PH_HALT; end
			end
			PH_FMT_ID: if (shift_field(b)) ph = (tag_sh == TAG_FMT) ? PH_FMT_SIZE : PH_SKIPSZ_A;
			PH_DATA_ID: if (shift_field(b)) ph = (tag_sh == TAG_DATA) ? PH_DATA_SIZE : PH_SKIPSZ_B;
			PH_SKIPSZ_A, PH_SKIPSZ_B: if (shift_field(b)) begin
				skip_rem = tag_sh;
				if (ph == PH_SKIPSZ_A) ph = (skip_rem == 0) ? PH_FMT_ID : PH_SKIP_A;
				else ph = (skip_rem == 0) ? PH_DATA_ID : PH_SKIP_B;
			end
			PH_SKIP_A, PH_SKIP_B: begin
				if (skip_rem > 0) skip_rem--;
				if (skip_rem == 0) ph = (ph == PH_SKIP_A) ? PH_FMT_ID : PH_DATA_ID;
			end
			PH_FMT_SIZE: if (shift_field(b)) begin
				skip_rem = tag_sh;
				fbc = 0;
				ph = (skip_rem == 0) ? PH_DATA_ID : PH_FMT_BODY;
			end
			PH_FMT_BODY: begin
				tag_sh = {b, tag_sh[31:8]};
				if (fbc == 1) afmt = tag_sh[31:16];
				else if (fbc == 3) ch_total = tag_sh[31:16];
				else if (fbc == 15) smp_bytes = tag_sh[31:19];
				if (fbc < 16) fbc++;
				if (skip_rem > 0) skip_rem--;
				if (skip_rem == 0) begin fbc = 0; ph = PH_DATA_ID; end
			end
			PH_DATA_SIZE: if (shift_field(b)) begin
				data_rem = tag_sh;
				if (ch_total == 0 || smp_bytes == 0 || data_rem == 0) begin
					status = ST_FMT;
					ph = PH_HALT;
				end else begin
					asm_word = '0;
					sb_idx = 0;
					ch_cnt = '0;
					ph = PH_DATA;
				end
			end
			PH_DATA: begin
				if (sb_idx < 4) asm_word = asm_word | (32'(b) << (8 * sb_idx));
				if (data_rem > 0) data_rem--;
				sb_idx++;
				if (sb_idx >= smp_bytes) begin
					got = 1;
					value = sample_q31();
					chan = ch_cnt;
					asm_word = '0;
					sb_idx = 0;
					ch_cnt = ch_cnt + 16'd1;
					if (ch_cnt >= ch_total) ch_cnt = '0;
				end
				if (data_rem == 0 && sb_idx == 0 && ch_cnt == 0) begin
					status = ST_DONE;
					ph = PH_HALT;
				end
			end
			default: ph = PH_HALT;
		endcase
		if (it.last_byte) begin
			if (!halted && status == ST_RUN) status = ST_TRUNC;
			parser_clear();
		end
		if (got || status != ST_RUN) begin
			r.sample_valid = got;
			r.sample_value = value;
			r.channel_index = chan;
			r.stream_status = status;
			result_q = {result_q, r};
		end
	endfunction

	task automatic put16(input logic [15:0] v);
		file_q = {file_q, v[7:0]};
		file_q = {file_q, v[15:8]};
	endtask

	task automatic put32(input logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endtask

	task automatic put_chunk(input logic [31:0] id);
		int n;
		n = $urandom_range(0, 6);
		put32(id);
		put32(n);
		repeat (n) file_q = {file_q, 8'($urandom)};
	endtask

	function automatic logic [31:0] float_word();
		case ($urandom_range(0, 11))
			0: return 32'h7F80_0000;
			1: return 32'hFF80_0000;
			2: return 32'h7FC0_0001;
			3: return 32'h3F80_0000;
			4: return 32'hBF80_0000;
			5: return 32'h3F7F_FFFF;
			6: return 32'hBF7F_FFFF;
			7: return 32'h0000_0001;
			8: return 32'h8000_0000;
			9: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic build_file(input logic [15:0] fmt_code, input logic [15:0] chans,
			input logic [15:0] bits, input int fmt_len, input int data_len, input int cut,
			input bit bad_riff, input bit bad_wave, input bit junk_a, input bit junk_b);
		logic [7:0] body[$];
		logic [31:0] w;
		int i;
		int extra;
		in_item_t it;
		file_q.delete();
		put32(bad_riff ? (TAG_RIFF ^ (32'h1 << $urandom_range(0, 31))) : TAG_RIFF);
		put32($urandom);
		put32(bad_wave ? (TAG_WAVE ^ (32'h1 << $urandom_range(0, 31))) : TAG_WAVE);
		if (junk_a) put_chunk(32'h4B4E_554A);
		put32(TAG_FMT);
		put32(fmt_len);
		put16(fmt_code);
		put16(chans);
		put32($urandom);
		put32($urandom);
		put16(16'($urandom));
		put16(bits);
		for (i = 0; i < 16; i++) body = {body, file_q.pop_back()};
		for (i = 0; i < fmt_len; i++)
			file_q = {file_q, (i < 16) ? body[15 - i] : 8'($urandom)};
		if (junk_b) put_chunk(32'h5453_494C);
		put32(TAG_DATA);
		put32(data_len);
		extra = $urandom_range(0, 6);
		for (i = 0; i < data_len + extra; i++) begin
			if (fmt_code == FMT_FLOAT && bits == 16'd32 && i % 4 == 0) begin
				w = float_word();
				put32(w);
				i += 3;
			end else begin
				file_q = {file_q, 8'($urandom)};
			end
		end
		if (cut >= 0 && cut < file_q.size())
			while (file_q.size() > cut + 1) void'(file_q.pop_back());
		foreach (file_q[k]) begin
			it = '{stream_byte: file_q[k], last_byte: (k == file_q.size() - 1)};
			byte_q = {byte_q, it};
		end
		bytes_sent += file_q.size();
		file_cnt++;
	endtask

	task automatic random_file();
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [15:0] bits;
		int          r;
		int          fmt_len;
		int          data_len;
		r = $urandom_range(0, 99);
		fmt_code = (r < 55) ? FMT_PCM : (r < 85) ? FMT_FLOAT : 16'($urandom);
		r = $urandom_range(0, 99);
		chans = (r < 5) ? 16'd0 : (r < 8) ? 16'hFFFF : 16'($urandom_range(1, 3));
		r = $urandom_range(0, 99);
		if (fmt_code == FMT_FLOAT && r < 70) bits = 16'd32;
		else if (r < 88) bits = 16'(8 * $urandom_range(1, 4));
		else if (r < 92) bits = 16'd0;
		else if (r < 96) bits = 16'($urandom_range(1, 7));
		else bits = 16'($urandom_range(33, 48));
		r = $urandom_range(0, 99);
		fmt_len = (r < 65) ? 16 : (r < 80) ? 18 : $urandom_range(0, 20);
		data_len = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 24);
		build_file(fmt_code, chans, bits, fmt_len, data_len,
			($urandom_range(0, 99) < 12) ? $urandom_range(0, 70) : -1,
			$urandom_range(0, 99) < 4, $urandom_range(0, 99) < 4,
			$urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			in_item <= '0;
		end else if (!push || !full) begin
			if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				push <= 1'b1;
				in_item <= byte_q.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_cnt <= 0;
			hold_seen <= 1'b0;
		end else if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_cnt <= 600;
			pop <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && !full)
			parse_byte(in_item);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (result_q.size() == 0) begin
				$error("unexpected result transaction: %p", out_item);
				fail_cnt++;
			end else begin
				want = result_q.pop_front();
				if (out_item.sample_valid !== want.sample_valid) begin
					$error("sample_valid: expected %0d, got %0d", want.sample_valid,
						out_item.sample_valid);
					fail_cnt++;
				end
				if (out_item.sample_value !== want.sample_value) begin
					$error("sample_value: expected %h, got %h", want.sample_value,
						out_item.sample_value);
					fail_cnt++;
				end
				if (out_item.channel_index !== want.channel_index) begin
					$error("channel_index: expected %0d, got %0d", want.channel_index,
						out_item.channel_index);
					fail_cnt++;
				end
				if (out_item.stream_status !== want.stream_status) begin
					$error("stream_status: expected %0d, got %0d", want.stream_status,
						out_item.stream_status);
					fail_cnt++;
				end
				if (want.sample_valid) samples_seen++;
				if (want.stream_status != ST_RUN) status_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("wav_stream_parser_top: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 0;
		fail_cnt = 0;
		bytes_sent = 0;
		samples_seen = 0;
		status_seen = 0;
		file_cnt = 0;
		idle_cycles = 0;
		parser_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		build_file(FMT_PCM, 16'd1, 16'd8, 16, 1, -1, 1, 0, 0, 0);
		build_file(FMT_PCM, 16'd2, 16'd16, 16, 3, -1, 0, 0, 1, 1);
		build_file(FMT_PCM, 16'd1, 16'd24, 16, 6, -1, 0, 1, 0, 0);
		build_file(FMT_FLOAT, 16'd1, 16'd32, 16, 16, -1, 0, 0, 0, 0);
		build_file(FMT_PCM, 16'd0, 16'd32, 12, 4, 50, 0, 0, 0, 0);
		hold_go = 1;

		for (int p = 0; p < 4; p++) begin
			idle_pct = (p == 1 || p == 3) ? 79 : 0;
			stall_pct = (p == 2) ? 79 : (p == 3) ? 24 : 0;
			if (p == 3) idle_pct = 24;
			random_file();
			while (bytes_sent < 60 * (p + 1) + 310) random_file();
			while (byte_q.size() > 0) @(posedge clk);
		end

		while (byte_q.size() > 0 || push || result_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d files and %0d bytes under four pacing phases,", file_cnt,
			bytes_sent);
		$display("with %0d samples and %0d final statuses checked.", samples_seen,
			status_seen);
		if (fail_cnt == 0 && result_q.size() == 0)
			$display("wav_stream_parser_top: match");
		else
			$display("wav_stream_parser_top: mismatch");
		$finish;
	end
endmodule
